[rtl/chc_pkg.sv]
// Shared types, header addresses, logo table and code constants for the header checker.
package chc_pkg;

    // Input word layout, from the lowest bit up: offset, data.
    localparam int OFFSET_W  = 9;
    localparam int DATA_W    = 8;
    localparam int S_TDATA_W = 24;

    // Result field widths.
    localparam int MODE_W    = 2;
    localparam int MAPPER_W  = 4;
    localparam int ROM_KB_W  = 21;
    localparam int RAM_KB_W  = 17;
    localparam int M_TDATA_W = 56;
    localparam int RESULT_W  = 3 + MODE_W + MAPPER_W + 5 + ROM_KB_W + RAM_KB_W;

    // Header byte addresses.
    localparam logic [OFFSET_W-1:0] LOGO_FIRST   = 9'h104;
    localparam logic [OFFSET_W-1:0] LOGO_LAST    = 9'h133;
    localparam logic [OFFSET_W-1:0] SUM_FIRST    = 9'h134;
    localparam logic [OFFSET_W-1:0] SUM_LAST     = 9'h14C;
    localparam logic [OFFSET_W-1:0] CHECK_ADDR   = 9'h14D;
    localparam logic [OFFSET_W-1:0] MODE_ADDR    = 9'h143;
    localparam logic [OFFSET_W-1:0] SUPER_ADDR   = 9'h146;
    localparam logic [OFFSET_W-1:0] TYPE_ADDR    = 9'h147;
    localparam logic [OFFSET_W-1:0] ROMCODE_ADDR = 9'h148;
    localparam logic [OFFSET_W-1:0] RAMCODE_ADDR = 9'h149;

    // Flag byte values.
    localparam logic [DATA_W-1:0] COLOUR_ONLY  = 8'hC0;
    localparam logic [DATA_W-1:0] COLOUR_DUAL  = 8'h80;
    localparam logic [DATA_W-1:0] SUPER_MARK   = 8'h03;

    // Size bases in kilobytes.
    localparam logic [ROM_KB_W-1:0] ROM_BASE_KB = 21'd32;
    localparam logic [RAM_KB_W-1:0] RAM_BASE_KB = 17'd2;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_BASE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLOUR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUPER  = 2'd2;

    // Mapper codes.
    localparam logic [MAPPER_W-1:0] MAP_NONE    = 4'd0;
    localparam logic [MAPPER_W-1:0] MAP_KIND1   = 4'd1;
    localparam logic [MAPPER_W-1:0] MAP_KIND2   = 4'd2;
    localparam logic [MAPPER_W-1:0] MAP_KIND3   = 4'd3;
    localparam logic [MAPPER_W-1:0] MAP_KIND5   = 4'd4;
    localparam logic [MAPPER_W-1:0] MAP_KIND6   = 4'd5;
    localparam logic [MAPPER_W-1:0] MAP_MULTI   = 4'd6;
    localparam logic [MAPPER_W-1:0] MAP_CAMERA  = 4'd7;
    localparam logic [MAPPER_W-1:0] MAP_TAMA    = 4'd8;
    localparam logic [MAPPER_W-1:0] MAP_HU3     = 4'd9;
    localparam logic [MAPPER_W-1:0] MAP_HU1     = 4'd10;
    localparam logic [MAPPER_W-1:0] MAP_UNKNOWN = 4'd11;

    // Decoded cartridge type.
    typedef struct packed {
        logic [MAPPER_W-1:0] mapper;
        logic                has_ram;
        logic                battery_backed;
        logic                clock_fitted;
        logic                motor_fitted;
        logic                tilt_fitted;
    } cart_info_t;

    localparam int LOGO_LEN = 48;
    localparam int LOGO_IDX_W = $clog2(LOGO_LEN);

    localparam logic [DATA_W-1:0] LOGO_TABLE [0:LOGO_LEN-1] = '{
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
    };

endpackage

[rtl/chc_type_decode.sv]
// Decoder from the cartridge-type byte to a mapper code and feature flags.
module chc_type_decode
    import chc_pkg::*;
(
    input  logic [DATA_W-1:0] cart_type,
    output cart_info_t        info
);

    always_comb begin
        info = '{mapper: MAP_UNKNOWN, default: 1'b0};
        unique case (cart_type)
            8'h00: info.mapper = MAP_NONE;
            8'h01: info.mapper = MAP_KIND1;
            8'h02: begin info.mapper = MAP_KIND1; info.has_ram = 1'b1; end
            8'h03: begin
                info.mapper = MAP_KIND1; info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h05: info.mapper = MAP_KIND2;
            8'h06: begin info.mapper = MAP_KIND2; info.battery_backed = 1'b1; end
            8'h08: begin info.mapper = MAP_NONE; info.has_ram = 1'b1; end
            8'h09: begin
                info.mapper = MAP_NONE; info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h0B: info.mapper = MAP_MULTI;
            8'h0C: begin info.mapper = MAP_MULTI; info.has_ram = 1'b1; end
            8'h0D: begin
                info.mapper = MAP_MULTI; info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h0F: begin
                info.mapper = MAP_KIND3; info.clock_fitted = 1'b1;
                info.battery_backed = 1'b1;
            end
            8'h10: begin
                info.mapper = MAP_KIND3; info.clock_fitted = 1'b1;
                info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h11: info.mapper = MAP_KIND3;
            8'h12: begin info.mapper = MAP_KIND3; info.has_ram = 1'b1; end
            8'h13: begin
                info.mapper = MAP_KIND3; info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h19: info.mapper = MAP_KIND5;
            8'h1A: begin info.mapper = MAP_KIND5; info.has_ram = 1'b1; end
            8'h1B: begin
                info.mapper = MAP_KIND5; info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h1C: begin info.mapper = MAP_KIND5; info.motor_fitted = 1'b1; end
            8'h1D: begin
                info.mapper = MAP_KIND5; info.motor_fitted = 1'b1; info.has_ram = 1'b1;
            end
            8'h1E: begin
                info.mapper = MAP_KIND5; info.motor_fitted = 1'b1;
                info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'h20: info.mapper = MAP_KIND6;
            // The tilt-sensor cartridge uses the fifth mapper kind with every feature but the clock.
            8'h22: begin
                info.mapper = MAP_KIND5; info.tilt_fitted = 1'b1; info.motor_fitted = 1'b1;
                info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            8'hFC: info.mapper = MAP_CAMERA;
            8'hFD: info.mapper = MAP_TAMA;
            8'hFE: info.mapper = MAP_HU3;
            8'hFF: begin
                info.mapper = MAP_HU1; info.has_ram = 1'b1; info.battery_backed = 1'b1;
            end
            default: info = '{mapper: MAP_UNKNOWN, default: 1'b0};
        endcase
    end

endmodule

[rtl/cart_header_checker.sv]
// Top level of the cartridge header checker: byte folding, verdict and output register.
//
// The block takes cartridge header bytes, one per word on the slave channel, each
// tagged with its address, in any order. The logo bytes are compared against the
// fixed logo, the checksum range is folded into a running sum, and the mode flags,
// cartridge type, size codes and stored checksum are captured. A word with s_tlast
// high closes the header: its byte is folded in first, then one verdict word goes
// out on the master channel and all header state returns to its reset values.
// Words without s_tlast produce no output word.
//
// The verdict word reaches the master channel through the input register and then
// the result register: the accepting edge loads the input register, and the edge
// on which the closing word advances loads the result register.
// Throughput: one word per cycle, sustained while no closing word waits behind a
// verdict not yet taken; the fold between the two registers is combinational.
//
// Reset (aresetn low at a rising edge) empties both registers and restores the
// header state. When the receiver stalls, the verdict waits in the output
// register; non-closing words keep flowing, and s_tready drops only while a
// closing word sits in the input register behind a verdict not yet taken.
module cart_header_checker
    import chc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Slave channel: header bytes.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // offset[8:0], data[16:9], zero fill above
    input  logic                 s_tlast,   // last: the closing header byte
    // Master channel: verdicts.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: valid_res, logo_ok, checksum_ok, mode[1:0], mapper[3:0],
    // has_ram, battery_backed, clock_fitted, motor_fitted, tilt_fitted,
    // rom_size_kb[20:0], ram_size_kb[16:0], zero fill above.
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Input register.
    logic                in_valid_reg;
    logic [OFFSET_W-1:0] in_offset_reg;
    logic [DATA_W-1:0]   in_data_reg;
    logic                in_last_reg;

    // Header state.
    logic              logo_match_reg,  logo_match_next;
    logic [DATA_W-1:0] running_sum_reg, running_sum_next;
    logic [DATA_W-1:0] stored_sum_reg,  stored_sum_next;
    logic              colour_reg,      colour_next;
    logic              super_reg,       super_next;
    logic [DATA_W-1:0] cart_type_reg,   cart_type_next;
    logic [DATA_W-1:0] rom_code_reg,    rom_code_next;
    logic [DATA_W-1:0] ram_code_reg,    ram_code_next;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                  advance;
    logic                  in_logo;
    logic                  in_sum;
    logic [OFFSET_W-1:0]   logo_diff;
    logic [LOGO_IDX_W-1:0] logo_idx;
    logic                  logo_ok;
    logic                  checksum_ok;
    logic [MODE_W-1:0]     mode;
    logic [ROM_KB_W-1:0]   rom_size_kb;
    logic [RAM_KB_W-1:0]   ram_size_kb;
    cart_info_t            info;
    logic [RESULT_W-1:0]   result;

    // A non-closing word never waits; a closing word needs room in the output register.
    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_offset_reg <= s_tdata[OFFSET_W-1:0];
            in_data_reg   <= s_tdata[OFFSET_W +: DATA_W];
            in_last_reg   <= s_tlast;
        end
    end

    // Fold the registered byte into the header state.
    assign in_logo   = (in_offset_reg >= LOGO_FIRST) && (in_offset_reg <= LOGO_LAST);
    assign in_sum    = (in_offset_reg >= SUM_FIRST) && (in_offset_reg <= SUM_LAST);
    assign logo_diff = in_offset_reg - LOGO_FIRST;
    assign logo_idx  = logo_diff[LOGO_IDX_W-1:0];

    always_comb begin
        logo_match_next  = logo_match_reg;
        running_sum_next = running_sum_reg;
        stored_sum_next  = stored_sum_reg;
        colour_next      = colour_reg;
        super_next       = super_reg;
        cart_type_next   = cart_type_reg;
        rom_code_next    = rom_code_reg;
        ram_code_next    = ram_code_reg;
        if (in_logo && (in_data_reg != LOGO_TABLE[logo_idx])) begin
            logo_match_next = 1'b0;
        end
        if (in_sum) begin
            running_sum_next = running_sum_reg - in_data_reg - 8'd1;
        end
        if (in_offset_reg == MODE_ADDR) begin
            colour_next = (in_data_reg == COLOUR_DUAL) || (in_data_reg == COLOUR_ONLY);
        end
        if (in_offset_reg == SUPER_ADDR) begin
            super_next = (in_data_reg == SUPER_MARK);
        end
        if (in_offset_reg == TYPE_ADDR) begin
            cart_type_next = in_data_reg;
        end
        if (in_offset_reg == ROMCODE_ADDR) begin
            rom_code_next = in_data_reg;
        end
        if (in_offset_reg == RAMCODE_ADDR) begin
            ram_code_next = in_data_reg;
        end
        if (in_offset_reg == CHECK_ADDR) begin
            stored_sum_next = in_data_reg;
        end
    end

    // After a verdict the state starts over for the next header.
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            logo_match_reg  <= 1'b1;
            running_sum_reg <= '0;
            stored_sum_reg  <= '0;
            colour_reg      <= 1'b0;
            super_reg       <= 1'b0;
            cart_type_reg   <= '0;
            rom_code_reg    <= '0;
            ram_code_reg    <= '0;
        end else if (advance) begin
            logo_match_reg  <= logo_match_next;
            running_sum_reg <= running_sum_next;
            stored_sum_reg  <= stored_sum_next;
            colour_reg      <= colour_next;
            super_reg       <= super_next;
            cart_type_reg   <= cart_type_next;
            rom_code_reg    <= rom_code_next;
            ram_code_reg    <= ram_code_next;
        end
    end

    // Verdict, taken from the state with the closing byte already folded in.
    chc_type_decode u_type_decode (
        .cart_type (cart_type_next),
        .info      (info)
    );

    assign logo_ok     = logo_match_next;
    assign checksum_ok = (running_sum_next == stored_sum_next);
    assign rom_size_kb = ROM_BASE_KB << rom_code_next[3:0];
    assign ram_size_kb = RAM_BASE_KB << ram_code_next[3:0];

    // The super flag overrides the colour flag.
    always_comb begin
        if (super_next) begin
            mode = MODE_SUPER;
        end else if (colour_next) begin
            mode = MODE_COLOUR;
        end else begin
            mode = MODE_BASE;
        end
    end

    assign result = {ram_size_kb, rom_size_kb, info.tilt_fitted, info.motor_fitted,
                     info.clock_fitted, info.battery_backed, info.has_ram, info.mapper,
                     mode, checksum_ok, logo_ok, logo_ok && checksum_ok};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_tdata_reg <= {{(M_TDATA_W - RESULT_W){1'b0}}, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/chc_checker.sv]
// Port-level assertions for the header checker and the bind that attaches them.
module chc_checker
    import chc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset leaves no verdict pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("verdict word present after reset");

    // A stalled verdict word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict word changed while stalled");

    // The overall verdict is the conjunction of the logo and checksum results.
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] && m_tdata[2])))
        else $error("valid_res disagrees with logo_ok and checksum_ok");

    // The mode field never carries the unused code.
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:3] == MODE_BASE || m_tdata[4:3] == MODE_COLOUR ||
                      m_tdata[4:3] == MODE_SUPER))
        else $error("mode field out of range");

    // Both size fields are powers of two.
    a_sizes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[34:14]) && $onehot(m_tdata[51:35]))
        else $error("size field is not a power of two");

endmodule

bind cart_header_checker chc_checker u_chc_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the cartridge header checker: directed rows, then random headers.
`timescale 1ns / 1ps

module tb_top;
    import chc_pkg::*;

    // One verdict as the checker reports it, kept in typed fields.
    typedef struct packed {
        logic                valid_res;
        logic                logo_ok;
        logic                checksum_ok;
        logic [MODE_W-1:0]   mode;
        cart_info_t          info;
        logic [ROM_KB_W-1:0] rom_kb;
        logic [RAM_KB_W-1:0] ram_kb;
    } verdict_t;

    // One row of the directed stimulus. When typed is set, want holds the verdict
    // written out by hand; otherwise the header model supplies it.
    typedef struct {
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   data;
        logic                closing;
        bit                  typed;
        verdict_t            want;
    } stim_row_t;

    // Every cartridge type code that decodes to a known mapper.
    localparam int N_TYPES  = 28;
    localparam int TYPE_IDX_W = $clog2(N_TYPES);
    localparam logic [DATA_W-1:0] KNOWN_TYPES [0:N_TYPES-1] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h08, 8'h09,
        8'h0B, 8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13,
        8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h20, 8'h22,
        8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    // Clock, reset and the two stream channels. Every input starts at a known value.
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Header model state. It mirrors what the checker has folded in so far and
    // returns to these values after every closing word.
    logic              logo_seen_ok = 1'b1;
    logic [DATA_W-1:0] hdr_sum      = '0;
    logic [DATA_W-1:0] stored_sum   = '0;
    logic              colour_seen  = 1'b0;
    logic              super_seen   = 1'b0;
    logic [DATA_W-1:0] cart_type    = '0;
    logic [DATA_W-1:0] rom_code     = '0;
    logic [DATA_W-1:0] ram_code     = '0;

    // Verdicts the checker still owes, oldest first.
    verdict_t verdicts_due[$];
    stim_row_t stim_rows[$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  closings_sent = 0;
    bit  send_rush     = 1'b0;
    bit  take_rush     = 1'b0;

    always #5 aclk = ~aclk;

    cart_header_checker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Cartridge type decode. The five flag bits after the mapper are, in order:
    // RAM, battery, timer, rumble, sensor.
    function automatic cart_info_t decode_cart_type(input logic [DATA_W-1:0] t);
        cart_info_t c;
        case (t)
            8'h00: c = {MAP_NONE,    5'b00000};
            8'h01: c = {MAP_KIND1,   5'b00000};
            8'h02: c = {MAP_KIND1,   5'b10000};
            8'h03: c = {MAP_KIND1,   5'b11000};
            8'h05: c = {MAP_KIND2,   5'b00000};
            8'h06: c = {MAP_KIND2,   5'b01000};
            8'h08: c = {MAP_NONE,    5'b10000};
            8'h09: c = {MAP_NONE,    5'b11000};
            8'h0B: c = {MAP_MULTI,   5'b00000};
            8'h0C: c = {MAP_MULTI,   5'b10000};
            8'h0D: c = {MAP_MULTI,   5'b11000};
            8'h0F: c = {MAP_KIND3,   5'b01100};
            8'h10: c = {MAP_KIND3,   5'b11100};
            8'h11: c = {MAP_KIND3,   5'b00000};
            8'h12: c = {MAP_KIND3,   5'b10000};
            8'h13: c = {MAP_KIND3,   5'b11000};
            8'h19: c = {MAP_KIND5,   5'b00000};
            8'h1A: c = {MAP_KIND5,   5'b10000};
            8'h1B: c = {MAP_KIND5,   5'b11000};
            8'h1C: c = {MAP_KIND5,   5'b00010};
            8'h1D: c = {MAP_KIND5,   5'b10010};
            8'h1E: c = {MAP_KIND5,   5'b11010};
            8'h20: c = {MAP_KIND6,   5'b00000};
            // The odd one: the fifth mapper kind with sensor and rumble on top.
            8'h22: c = {MAP_KIND5,   5'b11011};
            8'hFC: c = {MAP_CAMERA,  5'b00000};
            8'hFD: c = {MAP_TAMA,    5'b00000};
            8'hFE: c = {MAP_HU3,     5'b00000};
            8'hFF: c = {MAP_HU1,     5'b11000};
            default: c = {MAP_UNKNOWN, 5'b00000};
        endcase
        return c;
    endfunction

    // Folds one accepted header byte into the model. Returns 1 and fills v when the
    // byte closes the header; the model state is then cleared for the next header.
    function automatic bit fold_header_byte(input logic [OFFSET_W-1:0] off,
                                            input logic [DATA_W-1:0] d,
                                            input logic closing,
                                            output verdict_t v);
        v = '0;
        if (off >= LOGO_FIRST && off <= LOGO_LAST &&
            d != LOGO_TABLE[LOGO_IDX_W'(off - LOGO_FIRST)])
            logo_seen_ok = 1'b0;
        if (off >= SUM_FIRST && off <= SUM_LAST)
            hdr_sum = hdr_sum - d - 8'd1;
        if (off == MODE_ADDR)
            colour_seen = (d == COLOUR_DUAL || d == COLOUR_ONLY);
        if (off == SUPER_ADDR)
            super_seen = (d == SUPER_MARK);
        if (off == TYPE_ADDR)
            cart_type = d;
        if (off == ROMCODE_ADDR)
            rom_code = d;
        if (off == RAMCODE_ADDR)
            ram_code = d;
        if (off == CHECK_ADDR)
            stored_sum = d;
        if (!closing)
            return 1'b0;

        v.logo_ok     = logo_seen_ok;
        v.checksum_ok = (hdr_sum == stored_sum);
        v.valid_res   = v.logo_ok & v.checksum_ok;
        v.mode        = super_seen ? MODE_SUPER : (colour_seen ? MODE_COLOUR : MODE_BASE);
        v.info        = decode_cart_type(cart_type);
        v.rom_kb      = ROM_BASE_KB << rom_code[3:0];
        v.ram_kb      = RAM_BASE_KB << ram_code[3:0];

        logo_seen_ok = 1'b1;
        hdr_sum      = '0;
        stored_sum   = '0;
        colour_seen  = 1'b0;
        super_seen   = 1'b0;
        cart_type    = '0;
        rom_code     = '0;
        ram_code     = '0;
        return 1'b1;
    endfunction

    // The verdict of a header in which nothing but the logo and checksum state
    // was touched: base mode, no mapper, smallest sizes.
    function automatic verdict_t mk_verdict(input logic logo, input logic csum);
        verdict_t v;
        v             = '0;
        v.logo_ok     = logo;
        v.checksum_ok = csum;
        v.valid_res   = logo & csum;
        v.mode        = MODE_BASE;
        v.info        = {MAP_NONE, 5'b00000};
        v.rom_kb      = ROM_BASE_KB;
        v.ram_kb      = RAM_BASE_KB;
        return v;
    endfunction

    function automatic void add_row(input logic [OFFSET_W-1:0] off,
                                    input logic [DATA_W-1:0] d,
                                    input logic closing,
                                    input bit typed,
                                    input verdict_t want);
        stim_row_t r;
        r.off     = off;
        r.data    = d;
        r.closing = closing;
        r.typed   = typed;
        r.want    = want;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Sends one header byte. The gap before it is drawn per word unless the
    // sender is in a rush stretch. The verdict, if the byte closes a header, is
    // queued once the word has been taken.
    task automatic send_word(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] d,
                             input logic closing, input bit typed, input verdict_t typed_v);
        int unsigned gap;
        verdict_t    predicted;
        gap = send_rush ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({d, off});
        s_tlast  <= closing;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (fold_header_byte(off, d, closing, predicted)) begin
            verdicts_due.insert(verdicts_due.size(), typed ? typed_v : predicted);
            closings_sent++;
        end
    endtask

    // Takes the sender off the bus and holds it until every queued verdict has
    // come back.
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    // A complete header in shuffled order. Most are well formed; some carry a
    // bad logo byte, a bad stored checksum, missing bytes, or repeated and
    // stray bytes.
    task automatic send_full_header();
        logic [DATA_W-1:0]   img [0:511];
        logic [OFFSET_W-1:0] a;
        logic [DATA_W-1:0]   csum;
        logic [OFFSET_W-1:0] order[$];
        logic [OFFSET_W-1:0] tmp;
        int unsigned         flaw, j;
        int                  k;
        for (a = LOGO_FIRST; a <= LOGO_LAST; a++)
            img[a] = LOGO_TABLE[LOGO_IDX_W'(a - LOGO_FIRST)];
        for (a = SUM_FIRST; a <= SUM_LAST; a++)
            img[a] = DATA_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: img[MODE_ADDR] = COLOUR_ONLY;
            1: img[MODE_ADDR] = COLOUR_DUAL;
            2: img[MODE_ADDR] = 8'h00;
            default: img[MODE_ADDR] = DATA_W'($urandom_range(0, 255));
        endcase
        img[SUPER_ADDR] = ($urandom_range(0, 2) == 0) ? SUPER_MARK
                                                      : DATA_W'($urandom_range(0, 255));
        img[TYPE_ADDR]  = ($urandom_range(0, 3) != 0)
                          ? KNOWN_TYPES[TYPE_IDX_W'($urandom_range(0, N_TYPES - 1))]
                          : DATA_W'($urandom_range(0, 255));
        img[ROMCODE_ADDR] = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 255))
                                                        : DATA_W'($urandom_range(0, 8));
        img[RAMCODE_ADDR] = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 255))
                                                        : DATA_W'($urandom_range(0, 5));
        csum = '0;
        for (a = SUM_FIRST; a <= SUM_LAST; a++)
            csum = csum - img[a] - 8'd1;
        img[CHECK_ADDR] = csum;

        flaw = $urandom_range(0, 7);
        if (flaw == 4) begin
            a = LOGO_FIRST + OFFSET_W'($urandom_range(0, LOGO_LEN - 1));
            img[a] ^= (8'h01 << $urandom_range(0, 7));
        end
        if (flaw == 5)
            img[CHECK_ADDR] ^= (8'h01 << $urandom_range(0, 7));
        for (a = LOGO_FIRST; a <= CHECK_ADDR; a++)
            if (!(flaw == 6 && $urandom_range(0, 15) == 0))
                order.insert(order.size(), a);
        if (flaw == 7) begin
            // A repeated header byte and one stray byte on each side of the header.
            order.insert(order.size(), OFFSET_W'($urandom_range(LOGO_FIRST, CHECK_ADDR)));
            a = OFFSET_W'($urandom_range(CHECK_ADDR + 1, 511));
            img[a] = DATA_W'($urandom_range(0, 255));
            order.insert(order.size(), a);
            a = OFFSET_W'($urandom_range(0, LOGO_FIRST - 1));
            img[a] = DATA_W'($urandom_range(0, 255));
            order.insert(order.size(), a);
        end

        for (k = order.size() - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < order.size(); k++)
            send_word(order[k], img[order[k]], k == order.size() - 1, 1'b0,
                      mk_verdict(1'b1, 1'b1));
    endtask

    // A short run of loose bytes, mostly inside the header range, closed by its
    // last byte. These keep the verdicts coming at a reasonable rate.
    task automatic send_short_frame();
        int unsigned         len, k;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   d;
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
            off = ($urandom_range(0, 3) != 0)
                  ? OFFSET_W'($urandom_range(LOGO_FIRST, CHECK_ADDR))
                  : OFFSET_W'($urandom_range(0, 511));
            if (off >= LOGO_FIRST && off <= LOGO_LAST && $urandom_range(0, 1) == 1)
                d = LOGO_TABLE[LOGO_IDX_W'(off - LOGO_FIRST)];
            else
                d = DATA_W'($urandom_range(0, 255));
            send_word(off, d, k == len - 1, 1'b0, mk_verdict(1'b1, 1'b1));
        end
    endtask

    // Main stimulus: reset, the directed rows, then random headers, then the
    // final drain and verdict on the whole run.
    initial begin : header_source
        int k;
        // Lone closing bytes: reset verdict, extremes of the offset, and the
        // addresses just outside the header.
        add_row(9'h000, 8'h00, 1'b1, 1'b1, mk_verdict(1'b1, 1'b1));
        add_row(9'h1FF, 8'hFF, 1'b1, 1'b1, mk_verdict(1'b1, 1'b1));
        add_row(9'h14E, 8'h55, 1'b1, 1'b1, mk_verdict(1'b1, 1'b1));
        add_row(9'h103, 8'hAA, 1'b1, 1'b1, mk_verdict(1'b1, 1'b1));
        // A stored checksum with nothing summed, and logo bytes that miss.
        add_row(CHECK_ADDR, 8'hFF, 1'b1, 1'b1, mk_verdict(1'b1, 1'b0));
        add_row(LOGO_FIRST, 8'h00, 1'b1, 1'b1, mk_verdict(1'b0, 1'b1));
        add_row(LOGO_LAST,  8'h00, 1'b1, 1'b1, mk_verdict(1'b0, 1'b1));
        // Matching logo bytes at both ends of the logo.
        add_row(LOGO_FIRST, 8'hCE, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(LOGO_LAST,  8'h3E, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        // Color flag; then the super flag overriding it, and a later super byte, the last write winning.
        add_row(MODE_ADDR,  COLOUR_ONLY, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(MODE_ADDR,  COLOUR_DUAL, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(MODE_ADDR,  COLOUR_DUAL, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(SUPER_ADDR, SUPER_MARK,  1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(SUPER_ADDR, SUPER_MARK,  1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(SUPER_ADDR, 8'h04,       1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        // The sensor type, an unknown type and the top type code.
        add_row(TYPE_ADDR, 8'h22, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(TYPE_ADDR, 8'h04, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(TYPE_ADDR, 8'hFF, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        // Largest size codes, all bits set.
        add_row(ROMCODE_ADDR, 8'hFF, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(RAMCODE_ADDR, 8'hFF, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));
        // Repeated checksum byte, top of the sum range and a matching stored sum.
        add_row(SUM_FIRST,  8'h00, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(SUM_FIRST,  8'h00, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(SUM_LAST,   8'hFF, 1'b0, 1'b0, mk_verdict(1'b1, 1'b1));
        add_row(CHECK_ADDR, 8'hFE, 1'b1, 1'b0, mk_verdict(1'b1, 1'b1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < stim_rows.size(); k++)
            send_word(stim_rows[k].off, stim_rows[k].data, stim_rows[k].closing,
                      stim_rows[k].typed, stim_rows[k].want);

        // Let the checker run dry once before the random part starts.
        drain_verdicts();

        while (items_sent < 500 || closings_sent < 40) begin
            send_rush = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_verdicts();
            if ($urandom_range(0, 3) == 0)
                send_full_header();
            else
                send_short_frame();
        end
        s_tlast  <= 1'b0;

        // Wait for the last verdicts, then a few more cycles to catch any extra word.
        drain_verdicts();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Verdict sink: stalls at random, with stretches of no stalling, and compares
    // each taken word against the oldest queued verdict, field by field.
    initial begin : verdict_sink
        int unsigned          stall;
        verdict_t             want;
        logic [M_TDATA_W-1:0] w;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 11) == 0)
                take_rush = !take_rush;
            stall = take_rush ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            w = m_tdata;
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict expected none, got %h", $time, w);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("valid_res",   64'(want.valid_res),   64'(w[0]));
                check_field("logo_ok",     64'(want.logo_ok),     64'(w[1]));
                check_field("checksum_ok", 64'(want.checksum_ok), 64'(w[2]));
                check_field("mode",        64'(want.mode),        64'(w[4:3]));
                check_field("mapper",      64'(want.info.mapper), 64'(w[8:5]));
                check_field("has_ram",     64'(want.info.has_ram), 64'(w[9]));
                check_field("battery_backed", 64'(want.info.battery_backed), 64'(w[10]));
                check_field("clock_fitted", 64'(want.info.clock_fitted), 64'(w[11]));
                check_field("motor_fitted", 64'(want.info.motor_fitted), 64'(w[12]));
                check_field("tilt_fitted", 64'(want.info.tilt_fitted), 64'(w[13]));
                check_field("rom_size_kb", 64'(want.rom_kb),      64'(w[34:14]));
                check_field("ram_size_kb", 64'(want.ram_kb),      64'(w[51:35]));
                check_field("zero fill",   64'(0),                64'(w[M_TDATA_W-1:RESULT_W]));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/chc_pkg.sv
rtl/chc_type_decode.sv
rtl/cart_header_checker.sv
rtl/chc_checker.sv
verif/tb_top.sv
